FILE: hw/rtl/ksort_pkg.sv
// Shared types and codes for the keyed insertion sorter.
`default_nettype none

package ksort_pkg;

  // Operation codes carried by an input transaction.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_RD_WAIT,
    ST_DONE
  } state_e;

  // Port enables of the entry memory.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage : ksort_pkg

`default_nettype wire

FILE: hw/rtl/ksort_mem.sv
// Entry memory holding key and tag pairs, one write port and one registered read port.
`default_nettype none

module ksort_mem #(
  parameter int unsigned TABLE_DEPTH = 2048,
  parameter int unsigned KEY_BITS    = 24,
  parameter int unsigned TAG_BITS    = 11
) (
  input  logic                          clk_i,
  input  ksort_pkg::mem_ctl_t           ctl_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr_i,
  input  logic [KEY_BITS-1:0]           wr_key_i,
  input  logic [TAG_BITS-1:0]           wr_tag_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr_i,
  output logic [KEY_BITS-1:0]           rd_key_o,
  output logic [TAG_BITS-1:0]           rd_tag_o
);
  import ksort_pkg::*;

  localparam int unsigned EntryW = KEY_BITS + TAG_BITS;

  logic [EntryW-1:0] mem_q [TABLE_DEPTH];
  logic [EntryW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= {wr_key_i, wr_tag_i};
    end
  end

  // The read data register only changes on a read, so it holds its word while the
  // sequencer waits for the output register.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_key_o = rd_data_q[EntryW-1:TAG_BITS];
  assign rd_tag_o = rd_data_q[TAG_BITS-1:0];

endmodule : ksort_mem

`default_nettype wire

FILE: hw/rtl/ksort_ctrl.sv
// Sequencer for the sorter: count, largest key, insertion scan and result register.
`default_nettype none

module ksort_ctrl #(
  parameter int unsigned TABLE_DEPTH = 2048,
  parameter int unsigned KEY_BITS    = 24,
  parameter int unsigned TAG_BITS    = 11
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ksort_pkg::op_e                   op_i,
  input  logic signed [KEY_BITS-1:0]       sort_key_i,
  input  logic [TAG_BITS-1:0]              item_tag_i,
  input  logic                             item_alive_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   read_index_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [KEY_BITS-1:0]       out_key_o,
  output logic [TAG_BITS-1:0]              out_tag_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count_o,
  output logic                             overflow_o,
  output logic                             index_bad_o,
  output ksort_pkg::mem_ctl_t              mem_ctl_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]   mem_wr_addr_o,
  output logic [KEY_BITS-1:0]              mem_wr_key_o,
  output logic [TAG_BITS-1:0]              mem_wr_tag_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]   mem_rd_addr_o,
  input  logic [KEY_BITS-1:0]              mem_rd_key_i,
  input  logic [TAG_BITS-1:0]              mem_rd_tag_i
);
  import ksort_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(TABLE_DEPTH);
  localparam logic signed [KEY_BITS-1:0] KeyMin = {1'b1, {(KEY_BITS-1){1'b0}}};

  state_e                     state_q, state_d;
  logic [CntW-1:0]            count_q, count_d;
  logic signed [KEY_BITS-1:0] largest_q, largest_d;
  logic [CntW-1:0]            pos_q, pos_d;
  logic signed [KEY_BITS-1:0] key_q, key_d;
  logic [TAG_BITS-1:0]        tag_q, tag_d;

  logic                       out_valid_q, out_valid_d;
  logic signed [KEY_BITS-1:0] out_key_q, out_key_d;
  logic [TAG_BITS-1:0]        out_tag_q, out_tag_d;
  logic [CntW-1:0]            out_cnt_q, out_cnt_d;
  logic                       ovf_q, ovf_d;
  logic                       bad_q, bad_d;

  logic            out_free;
  logic            accept;
  logic [CntW-1:0] pos_m1;
  logic [CntW-1:0] pos_m2;
  logic [CntW-1:0] cnt_m1;
  logic [CntW-1:0] cnt_p1;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign pos_m1     = pos_q - CntW'(1);
  assign pos_m2     = pos_q - CntW'(2);
  assign cnt_m1     = count_q - CntW'(1);
  assign cnt_p1     = count_q + CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      largest_q   <= KeyMin;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      largest_q   <= largest_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    key_q     <= key_d;
    tag_q     <= tag_d;
    out_key_q <= out_key_d;
    out_tag_q <= out_tag_d;
    out_cnt_q <= out_cnt_d;
    ovf_q     <= ovf_d;
    bad_q     <= bad_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    largest_d   = largest_q;
    pos_d       = pos_q;
    key_d       = key_q;
    tag_d       = tag_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_key_d   = out_key_q;
    out_tag_d   = out_tag_q;
    out_cnt_d   = out_cnt_q;
    ovf_d       = ovf_q;
    bad_d       = bad_q;

    mem_ctl_o     = '0;
    mem_wr_addr_o = pos_q[IdxW-1:0];
    mem_wr_key_o  = key_q;
    mem_wr_tag_o  = tag_q;
    mem_rd_addr_o = pos_m2[IdxW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // Results of operations that finish in the idle state go straight to the output register.
          out_valid_d = 1'b1;
          out_key_d   = '0;
          out_tag_d   = '0;
          out_cnt_d   = count_q;
          ovf_d       = 1'b0;
          bad_d       = 1'b0;
          unique case (op_i)
            OP_INSERT: begin
              if (item_alive_i) begin
                if (count_q == DepthCnt) begin
                  ovf_d = 1'b1;
                end else if (sort_key_i >= largest_q) begin
                  mem_ctl_o.wr_en = 1'b1;
                  mem_wr_addr_o   = count_q[IdxW-1:0];
                  mem_wr_key_o    = sort_key_i;
                  mem_wr_tag_o    = item_tag_i;
                  count_d         = cnt_p1;
                  largest_d       = sort_key_i;
                  out_cnt_d       = cnt_p1;
                end else begin
                  // The table cannot be empty here, since the key lies below the largest.
                  out_valid_d     = 1'b0;
                  key_d           = sort_key_i;
                  tag_d           = item_tag_i;
                  pos_d           = count_q;
                  mem_ctl_o.rd_en = 1'b1;
                  mem_rd_addr_o   = cnt_m1[IdxW-1:0];
                  state_d         = ST_SHIFT;
                end
              end
            end
            OP_READ: begin
              if (CntW'(read_index_i) < count_q) begin
                out_valid_d     = 1'b0;
                mem_ctl_o.rd_en = 1'b1;
                mem_rd_addr_o   = read_index_i;
                state_d         = ST_RD_WAIT;
              end else begin
                bad_d = 1'b1;
              end
            end
            OP_CLEAR: begin
              count_d   = '0;
              largest_d = KeyMin;
              out_cnt_d = '0;
            end
            OP_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end

      ST_SHIFT: begin
        mem_ctl_o.wr_en = 1'b1;
        if ($signed(mem_rd_key_i) >= key_q) begin
          // Move the entry one place up and look at the next lower one.
          mem_wr_key_o = mem_rd_key_i;
          mem_wr_tag_o = mem_rd_tag_i;
          pos_d        = pos_m1;
          if (pos_q == CntW'(1)) begin
            state_d = ST_PLACE;
          end else begin
            mem_ctl_o.rd_en = 1'b1;
          end
        end else begin
          count_d = cnt_p1;
          state_d = ST_DONE;
        end
      end

      ST_PLACE: begin
        mem_ctl_o.wr_en = 1'b1;
        count_d         = cnt_p1;
        state_d         = ST_DONE;
      end

      ST_RD_WAIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_key_d   = mem_rd_key_i;
          out_tag_d   = mem_rd_tag_i;
          out_cnt_d   = count_q;
          ovf_d       = 1'b0;
          bad_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_key_d   = '0;
          out_tag_d   = '0;
          out_cnt_d   = count_q;
          ovf_d       = 1'b0;
          bad_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign out_key_o     = out_key_q;
  assign out_tag_o     = out_tag_q;
  assign entry_count_o = out_cnt_q;
  assign overflow_o    = ovf_q;
  assign index_bad_o   = bad_q;

  // The count never passes the table depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("entry count above table depth");

  // The count only steps up by one or drops to zero on a clear.
  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CntW'(1)) || (count_q == '0))
    else $error("entry count changed by an illegal step");

  // During the scan the insertion point lies inside the filled part of the table.
  a_scan_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (pos_q != '0) && (pos_q <= count_q))
    else $error("scan position out of range");

  // A simultaneous read and write never hit the same entry.
  a_mem_hazard : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_ctl_o.wr_en && mem_ctl_o.rd_en) |-> (mem_wr_addr_o != mem_rd_addr_o))
    else $error("read and write to the same entry in one cycle");

endmodule : ksort_ctrl

`default_nettype wire

FILE: hw/rtl/keyed_insertion_sorter.sv
// Top level of the keyed insertion sorter: sequencer and entry memory.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         in_valid_i / in_stall_o    op_i, sort_key_i, item_tag_i,
//                                                   item_alive_i, read_index_i
//   output    out        out_valid_o / out_stall_i  out_key_o, out_tag_o, entry_count_o,
//                                                   overflow_o, index_bad_o
//
// Clear, no-op, dead, dropped and appending inserts, and out-of-range reads complete in the
// idle state. An in-range read then waits for the entry memory's registered read data.
// An insert that must move k entries scans them one entry per cycle through the memory's
// read and write ports, places the item, then loads the result.
// Reset clears the count and the largest key; the entry memory needs no clearing pass,
// since only entries below the count are ever read.
// A stalled output holds one transaction and blocks the next from completing; the input
// is stalled while an operation is in progress or the output register is held.
`default_nettype none

module keyed_insertion_sorter #(
  parameter int unsigned TABLE_DEPTH = 2048,
  parameter int unsigned KEY_BITS    = 24,
  parameter int unsigned TAG_BITS    = 11
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ksort_pkg::op_e                   op_i,
  input  logic signed [KEY_BITS-1:0]       sort_key_i,
  input  logic [TAG_BITS-1:0]              item_tag_i,
  input  logic                             item_alive_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   read_index_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [KEY_BITS-1:0]       out_key_o,
  output logic [TAG_BITS-1:0]              out_tag_o,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] entry_count_o,
  output logic                             overflow_o,
  output logic                             index_bad_o
);
  import ksort_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  // Memory request and response between the sequencer and the entry store.
  mem_ctl_t            mem_ctl;
  logic [IdxW-1:0]     mem_wr_addr;
  logic [KEY_BITS-1:0] mem_wr_key;
  logic [TAG_BITS-1:0] mem_wr_tag;
  logic [IdxW-1:0]     mem_rd_addr;
  logic [KEY_BITS-1:0] mem_rd_key;
  logic [TAG_BITS-1:0] mem_rd_tag;

  // The sequencer owns the count, the largest key, the insertion scan and the result
  // register that parts the two channels.
  ksort_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .sort_key_i    (sort_key_i),
    .item_tag_i    (item_tag_i),
    .item_alive_i  (item_alive_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_key_o     (out_key_o),
    .out_tag_o     (out_tag_o),
    .entry_count_o (entry_count_o),
    .overflow_o    (overflow_o),
    .index_bad_o   (index_bad_o),
    .mem_ctl_o     (mem_ctl),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_key_o  (mem_wr_key),
    .mem_wr_tag_o  (mem_wr_tag),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_key_i  (mem_rd_key),
    .mem_rd_tag_i  (mem_rd_tag)
  );

  // The entry store keeps the sorted table, one key and tag pair per entry.
  ksort_mem #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BITS    (KEY_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .wr_addr_i (mem_wr_addr),
    .wr_key_i  (mem_wr_key),
    .wr_tag_i  (mem_wr_tag),
    .rd_addr_i (mem_rd_addr),
    .rd_key_o  (mem_rd_key),
    .rd_tag_o  (mem_rd_tag)
  );

endmodule : keyed_insertion_sorter

`default_nettype wire
